// ===== design/smm_pkg.sv =====
// Shared types and constants for the square matrix multiplier.
// Used by smm_feed, smm_cell and square_matrix_multiply_top; no dependencies.
package smm_pkg;

    // Default largest matrix dimension the storage is built for.
    localparam int MAX_DIM_DEF = 16;

    // Field widths.
    localparam int IDX_FW  = 4;
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 5;

    // Largest dimension the index fields can express.
    localparam int FIELD_DIM = 16;

    // Input action codes.
    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Kind of token that travels down the cell chain.
    typedef enum logic [1:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_COMP
    } t_kind;

    // One token of the chain. For loads, data holds the element value;
    // for compute tokens it holds the running dot product.
    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [IDX_FW-1:0]   row;
        logic [IDX_FW-1:0]   col;
        logic [DATA_W-1:0]   data;
        logic                last;
    } t_tok;

    // Sequencer states at the head of the chain.
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

// ===== design/smm_cell.sv =====
// One cell of the multiply chain: holds column K of A and row K of B.
// Depends on smm_pkg for the token type.
module smm_cell
    import smm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int K       = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_act,
    input  t_tok i_tok,
    output t_tok o_tok
);

    localparam int IDX_W = $clog2(MAX_DIM);

    logic [DATA_W-1:0] r_amem [MAX_DIM];
    logic [DATA_W-1:0] r_bmem [MAX_DIM];
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_p;
    t_tok              r_t1;
    t_tok              r_t2;
    t_tok              r_t3;
    t_tok              n_t3;
    logic [IDX_W-1:0]  w_row;
    logic [IDX_W-1:0]  w_col;

    assign w_row = IDX_W'(i_tok.row);
    assign w_col = IDX_W'(i_tok.col);

    // Element storage: A[row][K] lives at address row, B[K][col] at address col.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_tok.valid && i_tok.kind == K_LOAD_A && w_col == IDX_W'(K)) begin
                r_amem[w_row] <= i_tok.data;
            end
            if (i_tok.valid && i_tok.kind == K_LOAD_B && w_row == IDX_W'(K)) begin
                r_bmem[w_col] <= i_tok.data;
            end
            r_a <= r_amem[w_row];
            r_b <= r_bmem[w_col];
        end
    end

    // Product stage; cells beyond the active dimension add nothing.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_act ? r_a * r_b : '0;
        end
    end

    // Accumulate into compute tokens, pass loads through untouched.
    always_comb begin
        n_t3 = r_t2;
        if (r_t2.kind == K_COMP) begin
            n_t3.data = r_t2.data + r_p;
        end
    end

    // Token delay line alongside the read and multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
        end else if (i_en) begin
            r_t1 <= i_tok;
            r_t2 <= r_t1;
            r_t3 <= n_t3;
        end
    end

    assign o_tok = r_t3;

endmodule

// ===== design/smm_feed.sv =====
// Sequencer at the head of the chain: turns input items into chain tokens.
// Depends on smm_pkg for codes, the token type and the state type.
module smm_feed
    import smm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [DIM_W-1:0]  i_dim,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    input  logic [IDX_FW-1:0] i_row,
    input  logic [IDX_FW-1:0] i_col,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_ready,
    output logic              o_busy,
    output t_tok              o_tok
);

    t_state            r_state;
    t_state            n_state;
    logic [IDX_FW-1:0] r_row;
    logic [IDX_FW-1:0] n_row;
    logic [IDX_FW-1:0] r_col;
    logic [IDX_FW-1:0] n_col;
    logic              w_take;
    logic              w_row_in;
    logic              w_col_in;
    logic              w_run_last;

    assign w_take     = i_valid && o_ready;
    assign w_row_in   = {1'b0, i_row} < i_dim;
    assign w_col_in   = {1'b0, i_col} < i_dim;
    assign w_run_last = (DIM_W'(r_col) + DIM_W'(1)) == i_dim;

    // Next state: a compute item of more than one column enters the run state.
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take && i_action == ACT_COMPUTE && w_row_in && i_dim != DIM_W'(1)) begin
                    n_state = ST_RUN;
                    n_row   = i_row;
                    n_col   = IDX_FW'(1);
                end
            end
            ST_RUN: begin
                if (i_en) begin
                    n_col = r_col + IDX_FW'(1);
                    if (w_run_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake and the token handed to the first cell.
    always_comb begin
        o_ready        = 1'b0;
        o_busy         = 1'b0;
        o_tok.valid    = 1'b0;
        o_tok.kind     = K_COMP;
        o_tok.row      = i_row;
        o_tok.col      = i_col;
        o_tok.data     = i_value;
        o_tok.last     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = i_en;
                if (i_action == ACT_LOAD_A) begin
                    o_tok.kind  = K_LOAD_A;
                    o_tok.valid = w_take && w_row_in && w_col_in;
                end else if (i_action == ACT_LOAD_B) begin
                    o_tok.kind  = K_LOAD_B;
                    o_tok.valid = w_take && w_row_in && w_col_in;
                end else if (i_action == ACT_COMPUTE) begin
                    o_tok.col   = '0;
                    o_tok.data  = '0;
                    o_tok.last  = i_dim == DIM_W'(1);
                    o_tok.valid = w_take && w_row_in;
                end
            end
            ST_RUN: begin
                o_busy      = 1'b1;
                o_tok.valid = 1'b1;
                o_tok.row   = r_row;
                o_tok.col   = r_col;
                o_tok.data  = '0;
                o_tok.last  = w_run_last;
            end
            default: o_busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
    end

endmodule

// ===== design/square_matrix_multiply_top.sv =====
// Square matrix multiplier: a chain of MAX_DIM cells, cell k holding A[*][k] and B[k][*].
// A load is a single input item; a compute of one C row is issued by the sequencer as
// one column token per cycle while the chain is not stalled, taking no new item meanwhile.
// Each token passes registers r_t1, r_t2 and r_t3 in every cell, then the output register.
// Output stalls freeze the whole chain. Synchronous active-low reset empties the chain
// and sets the dimension to 16; matrix contents stay undefined until loaded.
module square_matrix_multiply_top
    import smm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // row [3:0], col [7:4], value [39:8]
    input  logic [1:0]  s_axis_tuser,   // action [1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row [3:0], out_col [7:4], product [39:8]
    output logic        m_axis_tlast,
    // Dimension register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // dim_in_use [4:0]
);

    localparam int DIM_CAP = (MAX_DIM < FIELD_DIM) ? MAX_DIM : FIELD_DIM;

    logic [DIM_W-1:0] r_cfg_dim;
    logic [DIM_W-1:0] w_dim;
    logic             w_en;
    logic             w_busy;
    logic [MAX_DIM-1:0] w_act;
    t_tok             w_tok [MAX_DIM+1];
    t_tok             r_out;
    logic             r_out_valid;

    // Dimension register, always ready to take a transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dim <= DIM_W'(16);
        end else if (i_cfg_valid) begin
            r_cfg_dim <= i_cfg_data;
        end
    end

    // Effective dimension clamped to 1 .. DIM_CAP.
    always_comb begin
        priority if (r_cfg_dim == '0) begin
            w_dim = DIM_W'(1);
        end else if (r_cfg_dim > DIM_W'(DIM_CAP)) begin
            w_dim = DIM_W'(DIM_CAP);
        end else begin
            w_dim = r_cfg_dim;
        end
    end

    // The chain advances whenever the output register is free or being emptied.
    assign w_en = !r_out_valid || m_axis_tready;

    smm_feed u_feed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_dim    (w_dim),
        .i_valid  (s_axis_tvalid),
        .i_action (s_axis_tuser),
        .i_row    (s_axis_tdata[3:0]),
        .i_col    (s_axis_tdata[7:4]),
        .i_value  (s_axis_tdata[39:8]),
        .o_ready  (s_axis_tready),
        .o_busy   (w_busy),
        .o_tok    (w_tok[0])
    );

    // Row of cells, each passing its token to the next.
    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        assign w_act[g] = 32'(g) < 32'(w_dim);

        smm_cell #(
            .MAX_DIM (MAX_DIM),
            .K       (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_act   (w_act[g]),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Output register: only finished compute tokens become results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_tok[MAX_DIM].valid && w_tok[MAX_DIM].kind == K_COMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= w_tok[MAX_DIM];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.data, r_out.col, r_out.row};
    assign m_axis_tlast  = r_out.last;

    // The last flag marks exactly the final column of the row.
    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == ((DIM_W'(r_out.col) + DIM_W'(1)) == w_dim)))
        else $error("tlast does not match the final column");

    // A result never names a row outside the matrix.
    a_row_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, r_out.row} < w_dim))
        else $error("result row outside the active dimension");

    // No input is taken while a row is still being sequenced.
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("input accepted during a row sequence");

endmodule
